@@ hdl/mbed_pkg.sv @@
// Package with shared constants and types for the multi-button edge debouncer.
package mbed_pkg;

  localparam int PIN_COUNT = 8;
  localparam int CNT_W = 8;

  localparam int REG_W = 8;
  localparam int LEVELS_W = 8;
  localparam int EVENT_PIN_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int PIN_IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int CNT_EXT_W = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int PIN_EXT_W = (PIN_COUNT > REG_W) ? PIN_COUNT : REG_W;
  localparam int IDX_EXT_W = (PIN_IDX_W > EVENT_PIN_W) ? PIN_IDX_W : EVENT_PIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_RISING_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd3;

  localparam logic [REG_W-1:0] LOCKOUT_RESET = 8'd4;

  typedef struct packed {
    logic fire;
    logic rise;
  } lane_evt_t;

endpackage

@@ hdl/multi_button_edge_debouncer_unit.sv @@
// Top level of the multi-button edge debouncer: configuration, pin lanes and merge.
// A result beat appears in the cycle after its scan tick is accepted.
// Throughput: one tick per cycle; input stalls only while a result beat is stalled.
// All pin lanes update in the same cycle; the merge stage holds one result beat.
// Reset clears levels, counters and masks and sets the lockout length to four.
module multi_button_edge_debouncer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mbed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbed_pkg::REG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [mbed_pkg::LEVELS_W-1:0]    pin_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mbed_pkg::EVENT_PIN_W-1:0] event_pin,
  output logic                             event_rising
);

  logic [mbed_pkg::REG_W-1:0]     rising_enable;
  logic [mbed_pkg::REG_W-1:0]     falling_enable;
  logic [mbed_pkg::REG_W-1:0]     restart_mask;
  logic [mbed_pkg::REG_W-1:0]     lockout_ticks;
  logic [mbed_pkg::CNT_EXT_W-1:0] reload_ext;
  logic [mbed_pkg::PIN_EXT_W-1:0] levels_ext;
  logic [mbed_pkg::PIN_EXT_W-1:0] rise_ext;
  logic [mbed_pkg::PIN_EXT_W-1:0] fall_ext;
  logic [mbed_pkg::PIN_EXT_W-1:0] restart_ext;
  logic                           accept;
  mbed_pkg::lane_evt_t            evt [mbed_pkg::PIN_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      rising_enable <= '0;
      falling_enable <= '0;
      restart_mask <= '0;
      lockout_ticks <= mbed_pkg::LOCKOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbed_pkg::REG_RISING_ENABLE:  rising_enable <= cfg_data;
        mbed_pkg::REG_FALLING_ENABLE: falling_enable <= cfg_data;
        mbed_pkg::REG_RESTART_MASK:   restart_mask <= cfg_data;
        mbed_pkg::REG_LOCKOUT_TICKS:  lockout_ticks <= cfg_data;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  assign reload_ext = mbed_pkg::CNT_EXT_W'(lockout_ticks);
  assign levels_ext = mbed_pkg::PIN_EXT_W'(pin_levels);
  assign rise_ext = mbed_pkg::PIN_EXT_W'(rising_enable);
  assign fall_ext = mbed_pkg::PIN_EXT_W'(falling_enable);
  assign restart_ext = mbed_pkg::PIN_EXT_W'(restart_mask);

  for (genvar g = 0; g < mbed_pkg::PIN_COUNT; g++) begin : g_lane
    mbed_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .accept  (accept),
      .capture (func),
      .now     (levels_ext[g]),
      .rise_en (rise_ext[g]),
      .fall_en (fall_ext[g]),
      .restart (restart_ext[g]),
      .reload  (reload_ext[mbed_pkg::CNT_W-1:0]),
      .evt     (evt[g])
    );
  end

  mbed_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .evt          (evt),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .event_pin    (event_pin),
    .event_rising (event_rising)
  );

endmodule

@@ hdl/mbed_lane.sv @@
// One pin lane: previous level, lockout counter and edge event detection.
module mbed_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      capture,
  input  logic                      now,
  input  logic                      rise_en,
  input  logic                      fall_en,
  input  logic                      restart,
  input  logic [mbed_pkg::CNT_W-1:0] reload,
  output mbed_pkg::lane_evt_t       evt
);

  logic                      prev;
  logic                      prev_next;
  logic [mbed_pkg::CNT_W-1:0] cnt;
  logic [mbed_pkg::CNT_W-1:0] cnt_next;
  logic                      enabled;
  logic                      running;

  assign enabled = now ? rise_en : fall_en;
  assign running = (cnt != '0);

  always_comb begin
    prev_next = prev;
    cnt_next = cnt;
    evt.fire = 1'b0;
    evt.rise = now;
    if (capture) begin
      prev_next = now;
    end else if (now != prev) begin
      prev_next = now;
      if (enabled) begin
        if (running) begin
          cnt_next = restart ? reload : cnt - 1'b1;
        end else begin
          cnt_next = reload;
          evt.fire = 1'b1;
        end
      end
    end else if (running) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 1'b0;
      cnt <= '0;
    end else if (accept) begin
      prev <= prev_next;
      cnt <= cnt_next;
    end
  end

endmodule

@@ hdl/mbed_merge.sv @@
// Merge stage: picks the highest-numbered firing lane and holds the result beat.
module mbed_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  mbed_pkg::lane_evt_t              evt [mbed_pkg::PIN_COUNT],
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [mbed_pkg::EVENT_PIN_W-1:0] event_pin,
  output logic                             event_rising
);

  logic                           any_fire;
  logic [mbed_pkg::PIN_IDX_W-1:0] sel_idx;
  logic                           sel_rise;
  logic [mbed_pkg::IDX_EXT_W-1:0] idx_ext;

  always_comb begin
    any_fire = 1'b0;
    sel_idx = '0;
    sel_rise = 1'b0;
    for (int i = 0; i < mbed_pkg::PIN_COUNT; i++) begin
      if (evt[i].fire) begin
        any_fire = 1'b1;
        sel_idx = mbed_pkg::PIN_IDX_W'(i);
        sel_rise = evt[i].rise;
      end
    end
  end

  assign idx_ext = mbed_pkg::IDX_EXT_W'(sel_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= any_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && any_fire) begin
      event_pin <= idx_ext[mbed_pkg::EVENT_PIN_W-1:0];
      event_rising <= sel_rise;
    end
  end

endmodule

@@ verif/mbed_checker.sv @@
// Checker for the debouncer: watches both channels, predicts key events and compares them.
`timescale 1ns / 1ps

module mbed_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mbed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbed_pkg::REG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             func,
  input  logic [mbed_pkg::LEVELS_W-1:0]    pin_levels,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [mbed_pkg::EVENT_PIN_W-1:0] event_pin,
  input  logic                             event_rising,
  input  logic                             run_done,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic [mbed_pkg::EVENT_PIN_W-1:0] pin;
    logic                             rising;
  } key_event_t;

  logic [mbed_pkg::REG_W-1:0] rise_en;
  logic [mbed_pkg::REG_W-1:0] fall_en;
  logic [mbed_pkg::REG_W-1:0] restart_en;
  logic [mbed_pkg::REG_W-1:0] lockout_len;

  logic [mbed_pkg::PIN_COUNT-1:0] last_level;
  logic [mbed_pkg::CNT_W-1:0]     lockout_left [mbed_pkg::PIN_COUNT];

  key_event_t expected_events [$];
  key_event_t oldest;
  logic       done_seen = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_tick(input logic capture, input logic [mbed_pkg::LEVELS_W-1:0] levels);
    int                         i;
    logic                       hit;
    logic                       hit_rise;
    logic [mbed_pkg::EVENT_PIN_W-1:0] hit_pin;
    logic                       now;
    logic                       enabled;
    logic [mbed_pkg::CNT_W-1:0] cnt;
    key_event_t                 ev;
    hit = 1'b0;
    hit_rise = 1'b0;
    hit_pin = '0;
    if (capture) begin
      last_level = levels[mbed_pkg::PIN_COUNT-1:0];
      return;
    end
    for (i = 0; i < mbed_pkg::PIN_COUNT; i++) begin
      now = levels[i];
      cnt = lockout_left[i];
      if (now != last_level[i]) begin
        enabled = now ? rise_en[i] : fall_en[i];
        if (enabled) begin
          if (cnt != '0) begin
            cnt = restart_en[i] ? lockout_len[mbed_pkg::CNT_W-1:0] : cnt - 1'b1;
          end else begin
            cnt = lockout_len[mbed_pkg::CNT_W-1:0];
            hit = 1'b1;
            hit_pin = i[mbed_pkg::EVENT_PIN_W-1:0];
            hit_rise = now;
          end
        end
        last_level[i] = now;
      end else if (cnt != '0) begin
        cnt = cnt - 1'b1;
      end
      lockout_left[i] = cnt;
    end
    if (hit) begin
      ev.pin = hit_pin;
      ev.rising = hit_rise;
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rise_en = '0;
      fall_en = '0;
      restart_en = '0;
      lockout_len = mbed_pkg::LOCKOUT_RESET;
      last_level = '0;
      foreach (lockout_left[i]) lockout_left[i] = '0;
      expected_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mbed_pkg::REG_RISING_ENABLE: rise_en = cfg_data;
          mbed_pkg::REG_FALLING_ENABLE: fall_en = cfg_data;
          mbed_pkg::REG_RESTART_MASK: restart_en = cfg_data;
          mbed_pkg::REG_LOCKOUT_TICKS: lockout_len = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event pin %0d rising %0b",
                                    event_pin, event_rising));
        end else begin
          oldest = expected_events.pop_front();
          if (oldest.pin !== event_pin || oldest.rising !== event_rising)
            report_mismatch($sformatf("event pin %0d rising %0b, expected pin %0d rising %0b",
                                      event_pin, event_rising, oldest.pin, oldest.rising));
        end
      end
      if (in_valid && !in_stall) predict_tick(func, pin_levels);
      if (run_done && !done_seen) begin
        done_seen = 1'b1;
        if (expected_events.size() != 0)
          report_mismatch($sformatf("%0d expected events never arrived",
                                    expected_events.size()));
      end
    end
    pending = expected_events.size();
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the debouncer: clock, reset, scan tick stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_CAPTURE = 1'b1;
  localparam int ITEMS_PER_PHASE = 183;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [mbed_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbed_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_SCAN;
  logic [mbed_pkg::LEVELS_W-1:0] pin_levels = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mbed_pkg::EVENT_PIN_W-1:0] event_pin;
  logic event_rising;
  logic run_done = 1'b0;
  int fail_count;
  int pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int quiet_cycles = 0;
  logic [mbed_pkg::LEVELS_W-1:0] cur_levels = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_button_edge_debouncer_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .pin_levels(pin_levels),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_pin(event_pin), .event_rising(event_rising)
  );

  mbed_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .pin_levels(pin_levels),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_pin(event_pin), .event_rising(event_rising),
    .run_done(run_done), .fail_count(fail_count), .pending(pending)
  );

  task automatic send_tick(input logic f, input logic [mbed_pkg::LEVELS_W-1:0] lv);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    pin_levels <= lv;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] rise_mask, input logic [7:0] fall_mask,
                            input logic [7:0] restart, input logic [7:0] ticks);
    wait_drained(4);
    cfg_write <= 1'b1;
    cfg_index <= mbed_pkg::REG_RISING_ENABLE;
    cfg_data <= rise_mask;
    @(posedge clk);
    cfg_index <= mbed_pkg::REG_FALLING_ENABLE;
    cfg_data <= fall_mask;
    @(posedge clk);
    cfg_index <= mbed_pkg::REG_RESTART_MASK;
    cfg_data <= restart;
    @(posedge clk);
    cfg_index <= mbed_pkg::REG_LOCKOUT_TICKS;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 25) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_lockout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(1, 6));
  endfunction

  task automatic send_random_tick();
    int r;
    logic [mbed_pkg::LEVELS_W-1:0] lv;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      lv = mbed_pkg::LEVELS_W'($urandom_range(0, 255));
      send_tick(FUNC_CAPTURE, lv);
    end else begin
      if (r < 16) lv = mbed_pkg::LEVELS_W'($urandom_range(0, 255));
      else if (r < 70) lv = cur_levels ^ (8'h01 << $urandom_range(0, 7));
      else lv = cur_levels;
      send_tick(FUNC_SCAN, lv);
    end
    cur_levels = lv;
  endtask

  initial begin : receiver
    int hold_seen;
    int k;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 51;

    // Zero lockout with every edge enabled: each scan tick with a change reports its highest-numbered changed pin.
    set_config(8'hFF, 8'hFF, 8'h00, 8'h00);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_SCAN, 8'hFF);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_CAPTURE, 8'h55);
    send_tick(FUNC_SCAN, 8'h55);
    send_tick(FUNC_SCAN, 8'hAA);
    send_tick(FUNC_SCAN, 8'h01);
    send_tick(FUNC_SCAN, 8'h00);

    // Split enables, restart on odd pins, short lockout.
    set_config(8'h0F, 8'hF0, 8'hAA, 8'h03);
    send_tick(FUNC_SCAN, 8'h01);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_SCAN, 8'h01);
    send_tick(FUNC_SCAN, 8'h01);
    send_tick(FUNC_SCAN, 8'h01);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_SCAN, 8'h02);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_SCAN, 8'h02);
    send_tick(FUNC_SCAN, 8'h80);
    send_tick(FUNC_SCAN, 8'h00);

    // Longest lockout, restart everywhere.
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(FUNC_SCAN, 8'hFF);
    send_tick(FUNC_SCAN, 8'h00);
    send_tick(FUNC_CAPTURE, 8'h0F);
    send_tick(FUNC_SCAN, 8'hF0);
    cur_levels = 8'hF0;

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 61 == 0) set_config(pick_mask(), pick_mask(), pick_mask(), pick_lockout());
        if (phase == 0 && n == 30) begin
          set_config(8'hFF, 8'hFF, 8'h00, 8'h00);
          hold_reqs = hold_reqs + 1;
        end
        if (phase == 1 && n == 90) wait_drained(1);
        send_random_tick();
      end
    end

    wait_drained(8);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ multi_button_edge_debouncer_unit.f @@
hdl/mbed_pkg.sv
hdl/mbed_lane.sv
hdl/mbed_merge.sv
hdl/multi_button_edge_debouncer_unit.sv
verif/mbed_checker.sv
verif/testbench.sv
